### sv/sawe_pkg.sv
// Shared types and constants for the stop-and-wait endpoint.
package sawe_pkg;

    localparam int CLIENT_ENTRIES_DEF = 16;
    localparam int ID_W   = 32;
    localparam int ADDR_W = 48;
    localparam int PORT_W = 16;
    localparam int LEN_W  = 16;

    typedef logic [ID_W-1:0]   t_id;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic              is_ack;
        t_id               seq_id;
        t_addr             src_address;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
        logic [LEN_W-1:0]  payload_length;
    } t_in;

    typedef struct packed {
        logic              send_ack;
        t_addr             ack_dest_address;
        logic [PORT_W-1:0] ack_dest_port;
        logic [PORT_W-1:0] ack_source_port;
        t_id               ack_id;
        logic [LEN_W-1:0]  ack_length;
        logic              deliver;
        logic              send_confirmed;
        t_id               outstanding_id;
        logic              table_full;
    } t_out;

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } t_state;

    typedef struct packed {
        logic commit;
        logic alloc;
        logic new_exp_one;
    } t_cell_cmd;

    typedef struct packed {
        logic valid;
        logic hit;
        logic le;
        logic eq;
    } t_cell_stat;

endpackage

### sv/sawe_cell.sv
// One client table cell: sender address, expected id and local compare.
module sawe_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cap,
    input  sawe_pkg::t_addr      i_cap_addr,
    input  sawe_pkg::t_id        i_cap_seq,
    input  sawe_pkg::t_addr      i_wr_addr,
    input  logic                 i_prev_valid,
    input  sawe_pkg::t_cell_cmd  i_cmd,
    output sawe_pkg::t_cell_stat o_stat
);

    logic            r_valid;
    logic            r_hit;
    logic            r_le;
    logic            r_eq;
    sawe_pkg::t_addr r_addr;
    sawe_pkg::t_id   r_exp;
    logic            w_match;
    logic            w_take;

    assign w_match = r_valid && (r_addr == i_cap_addr);
    assign w_take  = i_cmd.commit && i_cmd.alloc && i_prev_valid && !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
            r_le    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            if (i_cap) begin
                r_hit <= w_match;
                r_le  <= w_match && (i_cap_seq <= r_exp);
                r_eq  <= w_match && (i_cap_seq == r_exp);
            end
            if (w_take) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_addr <= i_wr_addr;
            r_exp  <= {{(sawe_pkg::ID_W-1){1'b0}}, i_cmd.new_exp_one};
        end else if (i_cmd.commit && r_hit && r_eq) begin
            r_exp  <= r_exp + sawe_pkg::ID_W'(1);
        end
    end

    assign o_stat.valid = r_valid;
    assign o_stat.hit   = r_hit;
    assign o_stat.le    = r_le;
    assign o_stat.eq    = r_eq;

endmodule

### sv/stop_and_wait_endpoint_top.sv
// Top level of the stop-and-wait endpoint, receive side.
// Input channel: one packet header per request (i_in_valid / o_in_ready,
// payload i_in). Output channel: one result per request (o_out_valid /
// i_out_ready, payload o_out).
// A header is taken in the idle state; every client cell compares its
// sender address and expected id against it at that edge. In the lookup
// state the cell flags are OR-reduced; once the output register is free,
// the result is formed into it and the cells and the send id update.
// A new request is taken only after the previous one has committed, since
// the input is not ready during the compare-then-commit pass (lookup).
// New senders take the first free cell; the valid flags pass down the row
// so a cell allocates when its left neighbor is in use and it is not.
// A new request is accepted while a finished result waits at the output.
// If the output stalls, the next request waits in the lookup state, cells
// untouched, until the output register frees.
// Reset clears the send id, all cell valid flags and the output valid.
module stop_and_wait_endpoint_top #(
    parameter int CLIENT_ENTRIES = sawe_pkg::CLIENT_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sawe_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sawe_pkg::t_out o_out
);

    sawe_pkg::t_state     r_state;
    sawe_pkg::t_state     n_state;
    sawe_pkg::t_in        r_req;
    sawe_pkg::t_id        r_send_id;
    sawe_pkg::t_id        n_send_id;
    sawe_pkg::t_out       r_out;
    sawe_pkg::t_out       n_out;
    logic                 r_out_valid;
    logic                 n_out_valid;

    logic                 w_accept;
    logic                 w_commit;
    logic                 w_confirm;
    logic                 w_hit_any;
    logic                 w_le_any;
    logic                 w_eq_any;
    logic                 w_full;
    logic                 w_le;
    logic                 w_eq;
    logic                 w_drop;
    sawe_pkg::t_cell_cmd  w_cmd;
    sawe_pkg::t_cell_stat w_stat [CLIENT_ENTRIES];
    logic [CLIENT_ENTRIES-1:0] w_valid;
    logic [CLIENT_ENTRIES-1:0] w_prev_valid;
    logic [CLIENT_ENTRIES-1:0] w_hit;
    logic [CLIENT_ENTRIES-1:0] w_le_vec;
    logic [CLIENT_ENTRIES-1:0] w_eq_vec;

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sawe_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = sawe_pkg::ST_LOOK;
                end
            end
            sawe_pkg::ST_LOOK: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = sawe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sawe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            sawe_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            sawe_pkg::ST_LOOK: begin
                w_commit = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
                w_commit   = 1'b0;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CLIENT_ENTRIES; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_prev_valid[g] = 1'b1;
            end else begin : g_rest
                assign w_prev_valid[g] = w_valid[g-1];
            end
            sawe_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cap        (w_accept),
                .i_cap_addr   (i_in.src_address),
                .i_cap_seq    (i_in.seq_id),
                .i_wr_addr    (r_req.src_address),
                .i_prev_valid (w_prev_valid[g]),
                .i_cmd        (w_cmd),
                .o_stat       (w_stat[g])
            );
            assign w_valid[g]  = w_stat[g].valid;
            assign w_hit[g]    = w_stat[g].hit;
            assign w_le_vec[g] = w_stat[g].le;
            assign w_eq_vec[g] = w_stat[g].eq;
        end
    endgenerate

    assign w_hit_any = |w_hit;
    assign w_le_any  = |w_le_vec;
    assign w_eq_any  = |w_eq_vec;
    assign w_full    = w_valid[CLIENT_ENTRIES-1];

    assign w_drop = !r_req.is_ack && !w_hit_any && w_full;
    assign w_le   = w_hit_any ? w_le_any : (r_req.seq_id == '0);
    assign w_eq   = w_hit_any ? w_eq_any : (r_req.seq_id == '0);

    assign w_cmd.commit      = w_commit && !r_req.is_ack;
    assign w_cmd.alloc       = !w_hit_any;
    assign w_cmd.new_exp_one = (r_req.seq_id == '0);

    assign w_confirm = r_req.is_ack && (r_req.seq_id == r_send_id);
    assign n_send_id = w_confirm ? (r_send_id + sawe_pkg::ID_W'(1)) : r_send_id;

    always_comb begin
        n_out                  = '0;
        n_out.send_confirmed   = w_confirm;
        n_out.outstanding_id   = n_send_id;
        n_out.table_full       = w_drop;
        if (!r_req.is_ack && !w_drop) begin
            n_out.deliver = w_eq;
            if (w_le) begin
                n_out.send_ack         = 1'b1;
                n_out.ack_dest_address = r_req.src_address;
                n_out.ack_dest_port    = r_req.src_port;
                n_out.ack_source_port  = r_req.dst_port;
                n_out.ack_id           = r_req.seq_id;
                n_out.ack_length       = r_req.payload_length;
            end
        end
    end

    assign n_out_valid = w_commit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sawe_pkg::ST_IDLE;
            r_send_id   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_commit) begin
                r_send_id <= n_send_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in;
        end
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_hit_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one client cell matched the sender");

    a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & ~w_prev_valid) == '0)
        else $error("client cell in use while its left neighbor is free");

    a_deliver_acked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out.deliver || o_out.send_ack))
        else $error("delivered request without acknowledgement");

    a_stall_holds_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(r_send_id))
        else $error("send id moved while the output was stalled");

endmodule
